>>> rtl/mixed_precision_dot_product_bf16_assert.svh
// Assertion macros for the mixed-precision dot product block.
`ifndef MIXED_PRECISION_DOT_PRODUCT_BF16_ASSERT_SVH
`define MIXED_PRECISION_DOT_PRODUCT_BF16_ASSERT_SVH

// same-cycle implication
`define MPDP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mpdp assertion failed");

// next-cycle implication
`define MPDP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mpdp assertion failed");

`endif

>>> rtl/mpdp_pkg.sv
// Types, codes and FP32/FP16/BF16 arithmetic helpers for the dot product block.
package mpdp_pkg;

	localparam logic [31:0] FP32_QNAN = 32'h7FC00000;
	localparam logic [15:0] BF16_QNAN = 16'h7FC0;

	typedef struct packed {
		logic [31:0] vec;
		logic [31:0] wid;
		logic [15:0] prior;
		logic        last;
		logic        lastcol;
	} term_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef struct packed {
		logic finishing;
		logic mul_busy;
	} back_stat_t;

	typedef struct packed {
		logic [27:0]        sum;
		logic signed [11:0] e;
		logic               sign;
		logic               spec;
		logic [31:0]        spec_val;
	} align_t;

	// exact FP16 -> FP32
	function automatic logic [31:0] fp16_widen(input logic [15:0] h);
		logic [31:0] r;
		logic [9:0]  m;
		logic [7:0]  e;
		logic [3:0]  s;
		m = h[9:0];
		s = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (m[i]) s = 4'(10 - i);
		end
		if (h[14:10] == 5'd0) begin
			if (m == 10'd0) begin
				r = {h[15], 31'd0};
			end else begin
				m = 10'(m << s);
				e = 8'd113 - {4'd0, s};
				r = {h[15], e, m, 13'd0};
			end
		end else if (h[14:10] == 5'h1F) begin
			if (m == 10'd0) r = {h[15], 8'hFF, 23'd0};
			else r = {h[15], 8'hFF, 1'b1, m[8:0], 13'd0};
		end else begin
			e = 8'({3'd0, h[14:10]} + 8'd112);
			r = {h[15], e, m, 13'd0};
		end
		return r;
	endfunction

	// value = M / 2^47 * 2^(E-127); round to nearest even into FP32
	function automatic logic [31:0] norm_round(input logic sign, input logic signed [11:0] e,
		input logic [47:0] m);
		logic [5:0]         lz;
		logic [47:0]        m2;
		logic [47:0]        m3;
		logic signed [11:0] e2;
		logic [11:0]        shw;
		logic [5:0]         sh;
		logic               lost;
		logic [7:0]         ef;
		logic               rnd;
		logic [30:0]        res;
		lz = 6'd48;
		for (int i = 0; i < 48; i++) begin
			if (m[i]) lz = 6'(47 - i);
		end
		if (m == 48'd0) return {sign, 31'd0};
		m2 = m << lz;
		e2 = e - signed'({6'd0, lz});
		if (e2 < 12'sd1) begin
			shw = 12'(12'sd1 - e2);
			sh = (shw > 12'd48) ? 6'd48 : shw[5:0];
			m3 = m2 >> sh;
			lost = |(m2 & ~(48'hFFFF_FFFF_FFFF << sh));
			ef = 8'd0;
		end else begin
			if (e2 >= 12'sd255) return {sign, 8'hFF, 23'd0};
			m3 = m2;
			lost = 1'b0;
			ef = e2[7:0];
		end
		rnd = m3[23] & (lost | (|m3[22:0]) | m3[24]);
		res = {ef, m3[46:24]} + {30'd0, rnd};
		return {sign, res};
	endfunction

	// FP32 add, first half: specials, swap, align, add/subtract
	function automatic align_t fp_align(input logic [31:0] x, input logic [31:0] y);
		align_t     r;
		logic       xinf, yinf, xnan, ynan, swap;
		logic [31:0] l, s;
		logic [7:0] el, es, d;
		logic [26:0] a, b0, b;
		logic       lost;
		xinf = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
		yinf = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
		xnan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
		ynan = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
		swap = y[30:0] > x[30:0];
		l = swap ? y : x;
		s = swap ? x : y;
		el = (l[30:23] == 8'd0) ? 8'd1 : l[30:23];
		es = (s[30:23] == 8'd0) ? 8'd1 : s[30:23];
		d = el - es;
		a = {(l[30:23] != 8'd0), l[22:0], 3'd0};
		b0 = {(s[30:23] != 8'd0), s[22:0], 3'd0};
		if (d >= 8'd27) begin
			b = 27'd0;
			lost = |b0;
		end else begin
			b = b0 >> d;
			lost = |(b0 & ~(27'h7FF_FFFF << d));
		end
		b[0] = b[0] | lost;
		r.sum = (l[31] != s[31]) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + {1'b0, b});
		r.sign = (r.sum == 28'd0) ? (x[31] & y[31]) : l[31];
		r.e = signed'({4'd0, el}) + 12'sd1;
		r.spec = xnan | ynan | xinf | yinf;
		if (xnan || ynan || (xinf && yinf && (x[31] != y[31]))) r.spec_val = FP32_QNAN;
		else if (xinf) r.spec_val = {x[31], 8'hFF, 23'd0};
		else r.spec_val = {y[31], 8'hFF, 23'd0};
		return r;
	endfunction

	function automatic logic [15:0] to_bf16(input logic [31:0] r);
		logic [31:0] t;
		if ((r[30:23] == 8'hFF) && (r[22:0] != 23'd0)) return BF16_QNAN;
		t = r + 32'h7FFF + {31'd0, r[16]};
		return t[31:16];
	endfunction

endpackage

>>> rtl/mpdp_fifo.sv
// Small term queue between the front and the back.
module mpdp_fifo import mpdp_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  term_t      din,
	input  logic       pop,
	output term_t      dout,
	output fifo_stat_t stat
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	term_t mem [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign dout = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem[wptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop) rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

>>> rtl/mpdp_front.sv
// Front: accepts words, widens the FP16 matrix element and queues the term.
module mpdp_front import mpdp_pkg::*; (
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] vector_value,
	input  logic [15:0] matrix_value,
	input  logic [15:0] prior_output,
	input  logic        last_term,
	input  logic        last_column,
	input  fifo_stat_t  qstat,
	output logic        push,
	output term_t       term
);
	assign in_ready = !qstat.full;
	assign push = in_valid && in_ready;

	always_comb begin
		term.vec     = vector_value;
		term.wid     = fp16_widen(matrix_value);
		term.prior   = prior_output;
		term.last    = last_term;
		term.lastcol = last_column;
	end
endmodule

>>> rtl/mpdp_back.sv
// Back: FP32 multiply pipeline, accumulate adder, prior add and BF16 output register.
module mpdp_back import mpdp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accp,
	input  fifo_stat_t  qstat,
	input  term_t       qdata,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] column_result,
	output logic        final_column,
	output back_stat_t  stat
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SUM  = 2'd1;
	localparam logic [1:0] ST_PRI  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	// multiply stage 1
	logic               m_v_s1, m_sign_s1, m_nan_s1, m_inf_s1, m_last_s1, m_lastcol_s1;
	logic [47:0]        m_p_s1;
	logic signed [11:0] m_e_s1;
	logic [15:0]        m_prior_s1;
	// multiply stage 2
	logic               m_v_s2, m_last_s2, m_lastcol_s2;
	logic [31:0]        m_prod_s2;
	logic [15:0]        m_prior_s2;
	// adder
	logic [1:0]         st_q;
	logic [31:0]        acc_q;
	align_t             al_q;
	logic               op_last_q, op_lastcol_q;
	logic [15:0]        op_prior_q;
	logic               out_valid_q, final_q;
	logic [15:0]        result_q;

	logic        take_prod, s2_free, s1_move, out_free, out_load;
	logic [31:0] ay, rsum, prod;
	align_t      al;
	logic        a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
	logic [7:0]  eea, eeb;
	logic [23:0] ma, mb;

	assign take_prod = m_v_s2 && (st_q == ST_IDLE);
	assign s2_free   = !m_v_s2 || take_prod;
	assign s1_move   = m_v_s1 && s2_free;
	assign pop       = !qstat.empty && (!m_v_s1 || s2_free);
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		a_zero = qdata.vec[30:0] == 31'd0;
		b_zero = qdata.wid[30:0] == 31'd0;
		a_inf  = (qdata.vec[30:23] == 8'hFF) && (qdata.vec[22:0] == 23'd0);
		b_inf  = (qdata.wid[30:23] == 8'hFF) && (qdata.wid[22:0] == 23'd0);
		a_nan  = (qdata.vec[30:23] == 8'hFF) && (qdata.vec[22:0] != 23'd0);
		b_nan  = (qdata.wid[30:23] == 8'hFF) && (qdata.wid[22:0] != 23'd0);
		eea = (qdata.vec[30:23] == 8'd0) ? 8'd1 : qdata.vec[30:23];
		eeb = (qdata.wid[30:23] == 8'd0) ? 8'd1 : qdata.wid[30:23];
		ma  = {(qdata.vec[30:23] != 8'd0), qdata.vec[22:0]};
		mb  = {(qdata.wid[30:23] != 8'd0), qdata.wid[22:0]};
	end

	always_comb begin
		if (m_nan_s1) prod = FP32_QNAN;
		else if (m_inf_s1) prod = {m_sign_s1, 8'hFF, 23'd0};
		else prod = norm_round(m_sign_s1, m_e_s1, m_p_s1);
	end

	assign ay   = (st_q == ST_PRI) ? {op_prior_q, 16'd0} : m_prod_s2;
	assign al   = fp_align(acc_q, ay);
	assign rsum = al_q.spec ? al_q.spec_val : norm_round(al_q.sign, al_q.e, {al_q.sum, 20'd0});
	assign out_load = ((st_q == ST_SUM) && op_last_q && !accp && out_free) ||
		((st_q == ST_FIN) && out_free);

	always_ff @(posedge clk) begin
		if (pop) begin
			m_p_s1       <= ma * mb;
			m_e_s1       <= signed'({4'd0, eea}) + signed'({4'd0, eeb}) - 12'sd126;
			m_sign_s1    <= qdata.vec[31] ^ qdata.wid[31];
			m_nan_s1     <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
			m_inf_s1     <= a_inf | b_inf;
			m_last_s1    <= qdata.last;
			m_lastcol_s1 <= qdata.lastcol;
			m_prior_s1   <= qdata.prior;
		end
		if (s1_move) begin
			m_prod_s2    <= prod;
			m_last_s2    <= m_last_s1;
			m_lastcol_s2 <= m_lastcol_s1;
			m_prior_s2   <= m_prior_s1;
		end
		if (take_prod || (st_q == ST_PRI)) al_q <= al;
		if (take_prod) begin
			op_last_q    <= m_last_s2;
			op_lastcol_q <= m_lastcol_s2;
			op_prior_q   <= m_prior_s2;
		end
		if (out_load) begin
			result_q <= to_bf16(rsum);
			final_q  <= op_lastcol_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_v_s1      <= 1'b0;
			m_v_s2      <= 1'b0;
			st_q        <= ST_IDLE;
			acc_q       <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) m_v_s1 <= 1'b1;
			else if (s1_move) m_v_s1 <= 1'b0;
			if (s1_move) m_v_s2 <= 1'b1;
			else if (take_prod) m_v_s2 <= 1'b0;

			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			case (st_q)
				ST_IDLE: begin
					if (take_prod) st_q <= ST_SUM;
				end
				ST_SUM: begin
					if (!op_last_q) begin
						acc_q <= rsum;
						st_q  <= ST_IDLE;
					end else if (accp) begin
						acc_q <= rsum;
						st_q  <= ST_PRI;
					end else if (out_free) begin
						acc_q <= 32'd0;
						st_q  <= ST_IDLE;
					end
				end
				ST_PRI: begin
					st_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						acc_q <= 32'd0;
						st_q  <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign column_result  = result_q;
	assign final_column   = final_q;
	assign stat.finishing = (st_q == ST_SUM) || (st_q == ST_FIN);
	assign stat.mul_busy  = m_v_s1 || m_v_s2;
endmodule

>>> rtl/mixed_precision_dot_product_bf16.sv
// An accepted term passes the queue, multiply stages s1 and s2, the align register and
// normalize/round; the loop-carried FP32 accumulate add (align step, then normalize/round
// step) takes a new product only when idle; a last term with prior add holds it through ST_PRI and ST_FIN.
// Reset: arst_n clears queue, pipeline valids, output valid and accumulate_prior; the
// running sum returns to +0.
// Top level: mixed-precision FP32 x FP16 dot product with BF16 column results.
module mixed_precision_dot_product_bf16 import mpdp_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        accumulate_prior,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] vector_value,
	input  logic [15:0] matrix_value,
	input  logic [15:0] prior_output,
	input  logic        last_term,
	input  logic        last_column,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] column_result,
	output logic        final_column
);
	`include "mixed_precision_dot_product_bf16_assert.svh"

	logic       accp_q;
	logic       push, pop;
	term_t      term, qdata;
	fifo_stat_t qstat;
	back_stat_t bstat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) accp_q <= 1'b0;
		else if (cfg_valid) accp_q <= accumulate_prior;
	end

	mpdp_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.vector_value (vector_value),
		.matrix_value (matrix_value),
		.prior_output (prior_output),
		.last_term    (last_term),
		.last_column  (last_column),
		.qstat        (qstat),
		.push         (push),
		.term         (term)
	);

	mpdp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (term),
		.pop    (pop),
		.dout   (qdata),
		.stat   (qstat)
	);

	mpdp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.accp          (accp_q),
		.qstat         (qstat),
		.qdata         (qdata),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.column_result (column_result),
		.final_column  (final_column),
		.stat          (bstat)
	);

	`MPDP_ASSERT_NEXT(a_push_fills, push, !qstat.empty)
	`MPDP_ASSERT_NEXT(a_pop_loads_mul, pop, bstat.mul_busy)
	`MPDP_ASSERT_NOW(a_out_from_adder, $rose(out_valid), $past(bstat.finishing))
	`MPDP_ASSERT_NOW(a_queue_sane, 1'b1, !(qstat.full && qstat.empty))
endmodule
